>>> src/tte_pkg.sv
// shared constants and bundle types for the tap tempo estimator
// no dependencies; used by tte_front and tap_tempo_estimator
package tte_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int MAX_RUN_DEF    = 4;
  localparam int CFG_WIDTH      = 32;
  localparam int TAPS_W         = 3;

  localparam logic [CFG_WIDTH-1:0] MSL_RESET = 32'd200;

  // one bit of each operand, least significant first
  typedef struct packed {
    logic prev;
    logic period;
    logic msl;
    logic tap;
    logic half;
  } front_bits_t;

  // outcome of the scan pass
  typedef struct packed {
    logic lt;
    logic gt_pos;
    logic gt_neg;
    logic ge;
    logic d_sign;
  } front_flags_t;

endpackage

>>> src/tte_front.sv
// bit-serial scan cell: deviation, interval and limit compares, lsb first
// depends on tte_pkg for the bit and flag bundles
module tte_front (
  input  logic                  clk,
  input  logic                  en,
  input  logic                  first,
  input  tte_pkg::front_bits_t  bits,
  output logic                  d_bit,
  output logic                  nd_bit,
  output tte_pkg::front_flags_t flags
);

  logic [1:0] c_d;
  logic [1:0] c_nd;
  logic       c_sum;
  logic       c_iv;
  logic [2:0] s_d;
  logic [2:0] s_nd;
  logic [1:0] s_sum;
  logic [1:0] s_iv;
  logic       sum_bit;
  logic       iv_bit;

  always_comb begin
    // d = prev + period - tap
    s_d = {2'b00, bits.prev} + {2'b00, bits.period} + {2'b00, ~bits.tap}
        + (first ? 3'd1 : {1'b0, c_d});
    // nd = tap - prev - period
    s_nd = {2'b00, bits.tap} + {2'b00, ~bits.prev} + {2'b00, ~bits.period}
         + (first ? 3'd2 : {1'b0, c_nd});
    // prev + max step length
    s_sum = {1'b0, bits.prev} + {1'b0, bits.msl} + (first ? 2'd0 : {1'b0, c_sum});
    // interval = tap - prev
    s_iv = {1'b0, bits.tap} + {1'b0, ~bits.prev} + (first ? 2'd1 : {1'b0, c_iv});
    d_bit   = s_d[0];
    nd_bit  = s_nd[0];
    sum_bit = s_sum[0];
    iv_bit  = s_iv[0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_d   <= s_d[2:1];
      c_nd  <= s_nd[2:1];
      c_sum <= s_sum[1];
      c_iv  <= s_iv[1];
      // lsb-first compares: a higher differing bit overrides
      flags.lt     <= (sum_bit != bits.tap) ? bits.tap : (first ? 1'b0 : flags.lt);
      flags.gt_pos <= (d_bit != bits.half) ? d_bit : (first ? 1'b0 : flags.gt_pos);
      flags.gt_neg <= (nd_bit != bits.half) ? nd_bit : (first ? 1'b0 : flags.gt_neg);
      flags.ge     <= (iv_bit != bits.period) ? iv_bit : (first ? 1'b1 : flags.ge);
      flags.d_sign <= d_bit;
    end
  end

endmodule

>>> src/tte_divider.sv
// restoring divider cell, one dividend bit per enabled cycle msb first
// divisor is narrow (run count plus one); no package dependencies
module tte_divider #(
  parameter int CW = 3
) (
  input  logic          clk,
  input  logic          start,
  input  logic          en,
  input  logic          bit_in,
  input  logic [CW-1:0] divisor,
  output logic          q_bit,
  output logic          rem_nz
);

  logic [CW-1:0] rem;
  logic [CW-1:0] rem_next;
  logic [CW:0]   trial;
  logic [CW:0]   trial_sub;

  always_comb begin
    trial     = {rem, bit_in};
    trial_sub = trial - {1'b0, divisor};
    q_bit     = (trial >= {1'b0, divisor});
    rem_next  = q_bit ? trial_sub[CW-1:0] : trial[CW-1:0];
    rem_nz    = |rem;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
    end else if (en) begin
      rem <= rem_next;
    end
  end

endmodule

>>> src/tte_adder.sv
// serial adder cell with a carry flop, lsb first
// no package dependencies
module tte_adder (
  input  logic clk,
  input  logic en,
  input  logic first,
  input  logic cin,
  input  logic a,
  input  logic b,
  output logic sum_bit
);

  logic carry;
  logic c;

  always_comb begin
    c       = first ? cin : carry;
    sum_bit = a ^ b ^ c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      carry <= (a & b) | (a & c) | (b & c);
    end
  end

endmodule

>>> src/tap_tempo_estimator.sv
// tap tempo estimator top level: sequencer, shift registers and output register
// depends on tte_pkg, tte_front, tte_divider and tte_adder
//
// each request on the input channel is the timestamp of one tap; each tap gives
// one result: whether it began a new run, the averaged tap period and the
// saturating count of intervals in the run. a tap restarts the run when it is
// the first since reset, when it comes later than the last tap plus
// max_step_length (wrapping), or when the run already has intervals and the
// tap deviates from the predicted time by more than half the period. otherwise
// the interval is folded in as floor((period*count + interval)/(count+1)).
// all arithmetic is bit serial, one bit per clock: a scan pass runs every
// compare and difference at once, then a tap that keeps the run takes a
// restoring divide pass and a serial add pass. a restarting tap goes through
// the scan, decide and finish states; an averaged tap goes through scan,
// decide, divide, add and finish before the next tap is accepted.
// a finished result sits in the output register, so the next tap is taken
// while it waits. max_step_length resets to 200 and is written only while idle
module tap_tempo_estimator #(
  parameter int TIME_WIDTH = tte_pkg::TIME_WIDTH_DEF,
  parameter int MAX_RUN    = tte_pkg::MAX_RUN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // tap input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [TIME_WIDTH-1:0]          tap_time,
  // result output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           restarted,
  output logic [TIME_WIDTH-1:0]          tap_period,
  output logic [tte_pkg::TAPS_W-1:0]     taps_in_run,
  // max step length write
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tte_pkg::CFG_WIDTH-1:0]  max_step_length
);

  localparam int CNT_W = $clog2(TIME_WIDTH);
  localparam int NW    = $clog2(MAX_RUN + 1);
  localparam int CW    = $clog2(MAX_RUN + 2);
  localparam int TW    = tte_pkg::TAPS_W;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(TIME_WIDTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_DIV,
    S_ADD,
    S_FINISH
  } state_t;

  state_t state;

  logic [CNT_W-1:0]      cnt;
  logic [TIME_WIDTH-1:0] prev;     // last tap time
  logic [TIME_WIDTH-1:0] period;   // averaged period
  logic [TIME_WIDTH-1:0] msl;      // max step length
  logic [TIME_WIDTH-1:0] tq;       // tap under work
  logic [TIME_WIDTH-1:0] dreg;     // prev + period - tap
  logic [TIME_WIDTH-1:0] ndreg;    // tap - prev - period
  logic [TIME_WIDTH-1:0] qreg;     // dividend, then quotient
  logic [NW-1:0]         count;
  logic                  started;
  logic                  res_restart;

  tte_pkg::front_bits_t  fbits;
  tte_pkg::front_flags_t flags;
  logic                  d_bit;
  logic                  nd_bit;
  logic                  cnt_last;
  logic                  restart_now;
  logic [CW-1:0]         divisor;
  logic                  q_bit;
  logic                  rem_nz;
  logic                  sum_bit;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign cnt_last  = (cnt == LAST);

  // registers rotate right during the scan, so bit 0 is the current bit;
  // half the period is the next bit up, zero at the top position
  always_comb begin
    fbits.prev   = prev[0];
    fbits.period = period[0];
    fbits.msl    = msl[0];
    fbits.tap    = tq[0];
    fbits.half   = !cnt_last && period[1];
  end

  // deviation magnitude is d or -d by the sign of d; -d covers the most
  // negative value as an unsigned half range, which always restarts a run with intervals
  assign restart_now = !started || flags.lt ||
                       ((count != '0) && (flags.d_sign ? flags.gt_neg : flags.gt_pos));

  assign divisor = CW'(count) + CW'(1);

  tte_front u_front (
    .clk   (clk),
    .en    (state == S_SCAN),
    .first (cnt == '0),
    .bits  (fbits),
    .d_bit (d_bit),
    .nd_bit(nd_bit),
    .flags (flags)
  );

  // dividend is interval - period when the interval is not shorter, else
  // period - interval; both were captured by the scan
  tte_divider #(
    .CW(CW)
  ) u_divider (
    .clk    (clk),
    .start  (state == S_DECIDE),
    .en     (state == S_DIV),
    .bit_in (qreg[TIME_WIDTH-1]),
    .divisor(divisor),
    .q_bit  (q_bit),
    .rem_nz (rem_nz)
  );

  // period + q, or period - q - (remainder nonzero) for the ceiling case
  tte_adder u_adder (
    .clk    (clk),
    .en     (state == S_ADD),
    .first  (cnt == '0),
    .cin    (!flags.ge && !rem_nz),
    .a      (period[0]),
    .b      (flags.ge ? qreg[0] : !qreg[0]),
    .sum_bit(sum_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      started   <= 1'b0;
      count     <= '0;
      prev      <= '0;
      period    <= '0;
      msl       <= TIME_WIDTH'(tte_pkg::MSL_RESET);
    end else begin
      if (cfg_valid && cfg_ready) begin
        msl <= TIME_WIDTH'(max_step_length);
      end
      // a finishing tap reloads the output register itself
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            tq    <= tap_time;
            cnt   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          prev   <= {prev[0], prev[TIME_WIDTH-1:1]};
          period <= {period[0], period[TIME_WIDTH-1:1]};
          msl    <= {msl[0], msl[TIME_WIDTH-1:1]};
          tq     <= {tq[0], tq[TIME_WIDTH-1:1]};
          dreg   <= {d_bit, dreg[TIME_WIDTH-1:1]};
          ndreg  <= {nd_bit, ndreg[TIME_WIDTH-1:1]};
          if (cnt_last) begin
            cnt   <= '0;
            state <= S_DECIDE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_DECIDE: begin
          started <= 1'b1;
          if (restart_now) begin
            prev        <= tq;
            period      <= '0;
            count       <= '0;
            res_restart <= 1'b1;
            state       <= S_FINISH;
          end else begin
            qreg        <= flags.ge ? ndreg : dreg;
            res_restart <= 1'b0;
            state       <= S_DIV;
          end
        end
        S_DIV: begin
          qreg <= {qreg[TIME_WIDTH-2:0], q_bit};
          if (cnt_last) begin
            cnt   <= '0;
            state <= S_ADD;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_ADD: begin
          period <= {sum_bit, period[TIME_WIDTH-1:1]};
          qreg   <= {1'b0, qreg[TIME_WIDTH-1:1]};
          if (cnt_last) begin
            cnt   <= '0;
            prev  <= tq;
            count <= (count == NW'(MAX_RUN)) ? count : count + NW'(1);
            state <= S_FINISH;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            restarted   <= res_restart;
            tap_period  <= period;
            taps_in_run <= TW'(count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // run count never passes its ceiling
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(MAX_RUN))
    else $error;

  // a restart always reports an empty run
  a_restart_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && restarted |-> (tap_period == '0) && (taps_in_run == '0))
    else $error;

  // the scan rotation hands back prev, period and msl unchanged
  a_scan_rotate: assert property (@(posedge clk) disable iff (rst)
    state == S_DECIDE |-> (prev == $past(prev, TIME_WIDTH)) &&
                          (period == $past(period, TIME_WIDTH)) &&
                          (msl == $past(msl, TIME_WIDTH)))
    else $error;
`endif

endmodule
